// ===== hdl/relaxed_newton_cubic_iteration_top_assert.svh =====
// ----------------------------------------------------------------------------
// relaxed newton cubic iteration assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef RELAXED_NEWTON_CUBIC_ITERATION_TOP_ASSERT_SVH
`define RELAXED_NEWTON_CUBIC_ITERATION_TOP_ASSERT_SVH

// same-cycle implication under reset
`define RNCMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rncmp check failed");

// next-cycle implication under reset
`define RNCMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rncmp check failed");

`endif

// ===== hdl/rncmp_pkg.sv =====
// ----------------------------------------------------------------------------
// rncmp_pkg
// widths, codes, sequencer states and saturating fixed point helpers
// ----------------------------------------------------------------------------
package rncmp_pkg;

    localparam int W = 32;
    localparam int F = 24;
    localparam int MAGW = 2 * W + 1;

    localparam logic signed [W-1:0] FX_ONE = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [W+1:0] CL_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] CL_MIN = {3'b111, {(W-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_MAX_ITER = 2'd0,
        CFG_EPS      = 2'd1,
        CFG_ALPHA_RE = 2'd2,
        CFG_ALPHA_IM = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_EPSQ, S_LOOP, S_SQ1, S_SQ2,
        S_W1, S_W2, S_W3, S_C1, S_C2, S_C3, S_C4,
        S_D1, S_D2, S_D3, S_P1, S_P2, S_P3, S_P4,
        S_QR, S_QI, S_T1, S_T2, S_T3, S_T4, S_Z, S_DONE
    } t_state;

    typedef struct packed {
        logic              ovf;
        logic signed [W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic            start;
        logic            neg;
        logic [2*W-1:0]  num;
        logic [2*W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic                ovf;
        logic signed [W-1:0] quo;
    } t_div_rsp;

    // sign and magnitude to word, clamping at the range ends
    function automatic t_sat fx_sat(input logic neg, input logic [MAGW-1:0] mag);
        logic [MAGW-1:0] lim_neg;
        t_sat r;
        lim_neg = MAGW'(1) << (W - 1);
        r.ovf = 1'b0;
        if (neg) begin
            if (mag > lim_neg) begin
                r.ovf = 1'b1;
                r.val = {1'b1, {(W-1){1'b0}}};
            end else begin
                r.val = -$signed(mag[W-1:0]);
            end
        end else begin
            if (mag > lim_neg - MAGW'(1)) begin
                r.ovf = 1'b1;
                r.val = {1'b0, {(W-1){1'b1}}};
            end else begin
                r.val = $signed(mag[W-1:0]);
            end
        end
        return r;
    endfunction

    // clamp an exact narrow signed sum to the word
    function automatic t_sat fx_clamp(input logic signed [W+1:0] s);
        t_sat r;
        r.ovf = 1'b0;
        r.val = s[W-1:0];
        if (s > CL_MAX) begin
            r.ovf = 1'b1;
            r.val = CL_MAX[W-1:0];
        end else if (s < CL_MIN) begin
            r.ovf = 1'b1;
            r.val = CL_MIN[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W+1:0] fx_ext(input logic signed [W-1:0] a);
        return {{2{a[W-1]}}, a};
    endfunction

    function automatic t_sat fx_add(input logic signed [W-1:0] a,
                                    input logic signed [W-1:0] b);
        return fx_clamp(fx_ext(a) + fx_ext(b));
    endfunction

    function automatic t_sat fx_sub(input logic signed [W-1:0] a,
                                    input logic signed [W-1:0] b);
        return fx_clamp(fx_ext(a) - fx_ext(b));
    endfunction

    function automatic t_sat fx_mul3(input logic signed [W-1:0] a);
        return fx_clamp(fx_ext(a) + (fx_ext(a) <<< 1));
    endfunction

    // round an exact magnitude product half away from zero
    function automatic t_sat fx_round(input logic [2*W-1:0] p, input logic neg);
        logic [MAGW-1:0] m;
        m = ({1'b0, p} + (MAGW'(1) << (F - 1))) >> F;
        return fx_sat(neg, m);
    endfunction

    function automatic logic [W-1:0] fx_abs(input logic signed [W-1:0] a);
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

endpackage

// ===== hdl/rncmp_in_if.sv =====
// ----------------------------------------------------------------------------
// rncmp_in_if
// start point channel: valid, ready and the complex start value
// ----------------------------------------------------------------------------
interface rncmp_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [rncmp_pkg::W-1:0] start_real;
    logic signed [rncmp_pkg::W-1:0] start_imag;

    modport source (output valid, output start_real, output start_imag, input ready);
    modport sink (input valid, input start_real, input start_imag, output ready);
endinterface

// ===== hdl/rncmp_out_if.sv =====
// ----------------------------------------------------------------------------
// rncmp_out_if
// result channel: final point, step count and overflow flag
// ----------------------------------------------------------------------------
interface rncmp_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [rncmp_pkg::W-1:0] final_real;
    logic signed [rncmp_pkg::W-1:0] final_imag;
    logic [7:0]                    steps_taken;
    logic                          overflow_flag;

    modport source (output valid, output final_real, output final_imag,
                    output steps_taken, output overflow_flag, input ready);
    modport sink (input valid, input final_real, input final_imag,
                  input steps_taken, input overflow_flag, output ready);
endinterface

// ===== hdl/rncmp_div.sv =====
// ----------------------------------------------------------------------------
// rncmp_div
// bit-serial restoring divider: floor(|n| * 2^F / d), signed, saturated
// ----------------------------------------------------------------------------
module rncmp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rncmp_pkg::t_div_req i_req,
    output rncmp_pkg::t_div_rsp o_rsp
);
    localparam int W  = rncmp_pkg::W;
    localparam int F  = rncmp_pkg::F;
    localparam int SH = W - F;
    localparam int CW = $clog2(W + 1);

    logic            r_busy, r_done, r_neg, r_big;
    logic [CW-1:0]   r_cnt;
    logic [2*W-1:0]  r_rem, r_den;
    logic [W-1:0]    r_sh, r_q;
    logic [2*W:0]    trial;
    logic            fits;
    logic            big;
    rncmp_pkg::t_sat res;

    // quotient would need more than a word: saturate without iterating
    assign big = {{SH{1'b0}}, i_req.num} >= {i_req.den, {SH{1'b0}}};

    // one quotient bit per cycle
    assign trial = {r_rem, r_sh[W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= big ? CW'(W) : '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_neg <= i_req.neg;
            r_big <= big;
            r_den <= i_req.den;
            r_rem <= i_req.num >> SH;
            r_sh  <= {i_req.num[SH-1:0], {F{1'b0}}};
            r_q   <= '0;
        end else if (r_busy && r_cnt != CW'(W)) begin
            r_rem <= fits ? (2*W)'(trial - {1'b0, r_den}) : trial[2*W-1:0];
            r_sh  <= r_sh << 1;
            r_q   <= {r_q[W-2:0], fits};
        end
    end

    assign res = rncmp_pkg::fx_sat(r_neg, r_big ? (rncmp_pkg::MAGW'(1) << W)
                                                : rncmp_pkg::MAGW'(r_q));
    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = res.ovf;
    assign o_rsp.quo  = res.val;
endmodule

// ===== hdl/relaxed_newton_cubic_iteration_top.sv =====
// ----------------------------------------------------------------------------
// relaxed_newton_cubic_iteration_top
// relaxed newton iteration for z^3 - 1 on one start point, Q8.24
// ----------------------------------------------------------------------------
// One start point is accepted when the block is idle; it then runs
// z <- z - alpha*(z^3-1)/(3z^2) up to max_iterations times, stopping early
// when |z| <= zero_epsilon or when 3z^2 is zero, and delivers one result word.
// Each step is a sequence of 19 products through one shared 32x32 multiplier
// and two bit-serial divisions, which set the rate. The result sits in an
// output register, so the next start point is taken while an earlier result
// still waits.
// ----------------------------------------------------------------------------
module relaxed_newton_cubic_iteration_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [rncmp_pkg::W-1:0]  i_cfg_data,
    rncmp_in_if.sink                 i_in,
    rncmp_out_if.source              o_out
);
    localparam int W = rncmp_pkg::W;

    rncmp_pkg::t_state r_state, n_state;

    // configuration
    logic [7:0]          r_max_iter;
    logic [W-2:0]        r_eps;
    logic signed [W-1:0] r_ar, r_ai;

    // working values
    logic signed [W-1:0] r_zr, r_zi, r_wr, r_wi, r_cr, r_ci, r_nr, r_dr, r_di;
    logic signed [W-1:0] r_qr, r_qi, r_tr, r_ti, r_t1;
    logic signed [W-1:0] n_zr, n_zi, n_wr, n_wi, n_cr, n_ci, n_nr, n_dr, n_di;
    logic signed [W-1:0] n_qr, n_qi, n_tr, n_ti, n_t1;
    logic [2*W-1:0]      r_acc, r_den, r_eps2, r_prod;
    logic [2*W-1:0]      n_acc, n_den, n_eps2;
    logic signed [2*W+1:0] r_sacc, r_pr, r_pi, n_sacc, n_pr, n_pi;
    logic                r_pneg, r_ovf, n_ovf;
    logic [7:0]          r_steps, n_steps;

    // output register
    logic                r_out_valid, n_out_valid;
    logic signed [W-1:0] r_fr, r_fi;
    logic [7:0]          r_fs;
    logic                r_fo;

    // shared multiplier
    logic signed [W-1:0] mul_a, mul_b;
    logic [2*W-1:0]      mul_p;

    rncmp_pkg::t_sat      rnd, s1, s2, s3, s4;
    logic signed [2*W+1:0] sp, pr_abs;
    logic [2*W:0]         sq_sum;
    logic                 near_zero;
    rncmp_pkg::t_div_req  div_req;
    rncmp_pkg::t_div_rsp  div_rsp;

    rncmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign mul_p = (2*W)'(rncmp_pkg::fx_abs(mul_a)) * (2*W)'(rncmp_pkg::fx_abs(mul_b));

    // views of the last product
    assign rnd       = rncmp_pkg::fx_round(r_prod, r_pneg);
    assign sp        = r_pneg ? -$signed({2'b00, r_prod}) : $signed({2'b00, r_prod});
    assign sq_sum    = {1'b0, r_acc} + {1'b0, r_prod};
    assign near_zero = {1'b0, r_eps2} >= sq_sum;
    assign pr_abs    = r_pr[2*W+1] ? -r_pr : r_pr;

    assign i_in.ready = (r_state == rncmp_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rncmp_pkg::S_IDLE: if (i_in.valid) n_state = rncmp_pkg::S_INIT;
            rncmp_pkg::S_INIT: n_state = rncmp_pkg::S_EPSQ;
            rncmp_pkg::S_EPSQ: n_state = rncmp_pkg::S_LOOP;
            rncmp_pkg::S_LOOP: n_state = (r_steps >= r_max_iter) ? rncmp_pkg::S_DONE
                                                                 : rncmp_pkg::S_SQ1;
            rncmp_pkg::S_SQ1:  n_state = rncmp_pkg::S_SQ2;
            rncmp_pkg::S_SQ2:  n_state = near_zero ? rncmp_pkg::S_DONE : rncmp_pkg::S_W1;
            rncmp_pkg::S_W1:   n_state = rncmp_pkg::S_W2;
            rncmp_pkg::S_W2:   n_state = rncmp_pkg::S_W3;
            rncmp_pkg::S_W3:   n_state = rncmp_pkg::S_C1;
            rncmp_pkg::S_C1:   n_state = rncmp_pkg::S_C2;
            rncmp_pkg::S_C2:   n_state = rncmp_pkg::S_C3;
            rncmp_pkg::S_C3:   n_state = rncmp_pkg::S_C4;
            rncmp_pkg::S_C4:   n_state = rncmp_pkg::S_D1;
            rncmp_pkg::S_D1:   n_state = rncmp_pkg::S_D2;
            rncmp_pkg::S_D2:   n_state = rncmp_pkg::S_D3;
            rncmp_pkg::S_D3:   n_state = (r_dr == '0 && r_di == '0) ? rncmp_pkg::S_DONE
                                                                    : rncmp_pkg::S_P1;
            rncmp_pkg::S_P1:   n_state = rncmp_pkg::S_P2;
            rncmp_pkg::S_P2:   n_state = rncmp_pkg::S_P3;
            rncmp_pkg::S_P3:   n_state = rncmp_pkg::S_P4;
            rncmp_pkg::S_P4:   n_state = rncmp_pkg::S_QR;
            rncmp_pkg::S_QR:   if (div_rsp.done) n_state = rncmp_pkg::S_QI;
            rncmp_pkg::S_QI:   if (div_rsp.done) n_state = rncmp_pkg::S_T1;
            rncmp_pkg::S_T1:   n_state = rncmp_pkg::S_T2;
            rncmp_pkg::S_T2:   n_state = rncmp_pkg::S_T3;
            rncmp_pkg::S_T3:   n_state = rncmp_pkg::S_T4;
            rncmp_pkg::S_T4:   n_state = rncmp_pkg::S_Z;
            rncmp_pkg::S_Z:    n_state = rncmp_pkg::S_LOOP;
            rncmp_pkg::S_DONE: if (!r_out_valid) n_state = rncmp_pkg::S_IDLE;
            default:           n_state = rncmp_pkg::S_IDLE;
        endcase
    end

    // datapath controls per state
    always_comb begin
        n_zr = r_zr; n_zi = r_zi; n_wr = r_wr; n_wi = r_wi; n_cr = r_cr;
        n_ci = r_ci; n_nr = r_nr; n_dr = r_dr; n_di = r_di; n_qr = r_qr;
        n_qi = r_qi; n_tr = r_tr; n_ti = r_ti; n_t1 = r_t1;
        n_acc = r_acc; n_den = r_den; n_eps2 = r_eps2;
        n_sacc = r_sacc; n_pr = r_pr; n_pi = r_pi;
        n_ovf = r_ovf; n_steps = r_steps;
        n_out_valid = r_out_valid & ~o_out.ready;
        mul_a = '0;
        mul_b = '0;
        s1 = '0; s2 = '0; s3 = '0; s4 = '0;
        div_req.start = 1'b0;
        div_req.neg   = r_pr[2*W+1];
        div_req.num   = pr_abs[2*W-1:0];
        div_req.den   = r_den;
        case (r_state)
            rncmp_pkg::S_IDLE: begin
                n_zr = i_in.start_real;
                n_zi = i_in.start_imag;
                n_ovf = 1'b0;
                n_steps = '0;
            end
            rncmp_pkg::S_INIT: begin
                mul_a = $signed({1'b0, r_eps});
                mul_b = $signed({1'b0, r_eps});
            end
            rncmp_pkg::S_EPSQ: n_eps2 = r_prod;
            rncmp_pkg::S_LOOP: begin
                mul_a = r_zr; mul_b = r_zr;
            end
            rncmp_pkg::S_SQ1: begin
                n_acc = r_prod;
                mul_a = r_zi; mul_b = r_zi;
            end
            rncmp_pkg::S_SQ2: begin
                mul_a = r_zr; mul_b = r_zr;
            end
            rncmp_pkg::S_W1: begin
                n_t1 = rnd.val; n_ovf = r_ovf | rnd.ovf;
                mul_a = r_zi; mul_b = r_zi;
            end
            rncmp_pkg::S_W2: begin
                s1 = rncmp_pkg::fx_sub(r_t1, rnd.val);
                n_wr = s1.val; n_ovf = r_ovf | rnd.ovf | s1.ovf;
                mul_a = r_zr; mul_b = r_zi;
            end
            rncmp_pkg::S_W3: begin
                s1 = rncmp_pkg::fx_add(rnd.val, rnd.val);
                n_wi = s1.val; n_ovf = r_ovf | rnd.ovf | s1.ovf;
                mul_a = r_wr; mul_b = r_zr;
            end
            rncmp_pkg::S_C1: begin
                n_t1 = rnd.val; n_ovf = r_ovf | rnd.ovf;
                mul_a = r_wi; mul_b = r_zi;
            end
            rncmp_pkg::S_C2: begin
                s1 = rncmp_pkg::fx_sub(r_t1, rnd.val);
                n_cr = s1.val; n_ovf = r_ovf | rnd.ovf | s1.ovf;
                mul_a = r_wr; mul_b = r_zi;
            end
            rncmp_pkg::S_C3: begin
                n_t1 = rnd.val; n_ovf = r_ovf | rnd.ovf;
                mul_a = r_wi; mul_b = r_zr;
            end
            rncmp_pkg::S_C4: begin
                // imag of z^3, numerator real, and 3 z^2
                s1 = rncmp_pkg::fx_add(r_t1, rnd.val);
                s2 = rncmp_pkg::fx_sub(r_cr, rncmp_pkg::FX_ONE);
                s3 = rncmp_pkg::fx_mul3(r_wr);
                s4 = rncmp_pkg::fx_mul3(r_wi);
                n_ci = s1.val; n_nr = s2.val; n_dr = s3.val; n_di = s4.val;
                n_ovf = r_ovf | rnd.ovf | s1.ovf | s2.ovf | s3.ovf | s4.ovf;
            end
            rncmp_pkg::S_D1: begin
                mul_a = r_dr; mul_b = r_dr;
            end
            rncmp_pkg::S_D2: begin
                n_acc = r_prod;
                mul_a = r_di; mul_b = r_di;
            end
            rncmp_pkg::S_D3: begin
                n_den = sq_sum[2*W-1:0];
                if (r_dr == '0 && r_di == '0) n_ovf = 1'b1;
                mul_a = r_nr; mul_b = r_dr;
            end
            rncmp_pkg::S_P1: begin
                n_sacc = sp;
                mul_a = r_ci; mul_b = r_di;
            end
            rncmp_pkg::S_P2: begin
                n_pr = r_sacc + sp;
                mul_a = r_ci; mul_b = r_dr;
            end
            rncmp_pkg::S_P3: begin
                n_sacc = sp;
                mul_a = r_nr; mul_b = r_di;
            end
            rncmp_pkg::S_P4: begin
                n_pi = r_sacc - sp;
                div_req.start = 1'b1;
            end
            rncmp_pkg::S_QR: begin
                // second division on the imaginary numerator
                n_pr = r_pi;
                if (div_rsp.done) begin
                    n_qr = div_rsp.quo;
                    n_ovf = r_ovf | div_rsp.ovf;
                    div_req.start = 1'b1;
                    div_req.neg = r_pi[2*W+1];
                    div_req.num = r_pi[2*W+1] ? (2*W)'(-r_pi) : r_pi[2*W-1:0];
                end
            end
            rncmp_pkg::S_QI: begin
                if (div_rsp.done) begin
                    n_qi = div_rsp.quo;
                    n_ovf = r_ovf | div_rsp.ovf;
                end
                mul_a = r_ar; mul_b = r_qr;
            end
            rncmp_pkg::S_T1: begin
                n_t1 = rnd.val; n_ovf = r_ovf | rnd.ovf;
                mul_a = r_ai; mul_b = r_qi;
            end
            rncmp_pkg::S_T2: begin
                s1 = rncmp_pkg::fx_sub(r_t1, rnd.val);
                n_tr = s1.val; n_ovf = r_ovf | rnd.ovf | s1.ovf;
                mul_a = r_ar; mul_b = r_qi;
            end
            rncmp_pkg::S_T3: begin
                n_t1 = rnd.val; n_ovf = r_ovf | rnd.ovf;
                mul_a = r_ai; mul_b = r_qr;
            end
            rncmp_pkg::S_T4: begin
                s1 = rncmp_pkg::fx_add(r_t1, rnd.val);
                n_ti = s1.val; n_ovf = r_ovf | rnd.ovf | s1.ovf;
            end
            rncmp_pkg::S_Z: begin
                s1 = rncmp_pkg::fx_sub(r_zr, r_tr);
                s2 = rncmp_pkg::fx_sub(r_zi, r_ti);
                n_zr = s1.val; n_zi = s2.val;
                n_ovf = r_ovf | s1.ovf | s2.ovf;
                n_steps = r_steps + 8'd1;
            end
            rncmp_pkg::S_DONE: begin
                if (!r_out_valid) n_out_valid = 1'b1;
            end
            default: begin
                n_ovf = r_ovf;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rncmp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_max_iter  <= 8'd255;
            r_eps       <= (W-1)'(1678);
            r_ar        <= W'(18454938);
            r_ai        <= W'(12582912);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (rncmp_pkg::t_cfg_idx'(i_cfg_index))
                    rncmp_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[7:0];
                    rncmp_pkg::CFG_EPS:      r_eps      <= i_cfg_data[W-2:0];
                    rncmp_pkg::CFG_ALPHA_RE: r_ar       <= $signed(i_cfg_data);
                    rncmp_pkg::CFG_ALPHA_IM: r_ai       <= $signed(i_cfg_data);
                    default:                 r_max_iter <= r_max_iter;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_zr <= n_zr; r_zi <= n_zi; r_wr <= n_wr; r_wi <= n_wi; r_cr <= n_cr;
        r_ci <= n_ci; r_nr <= n_nr; r_dr <= n_dr; r_di <= n_di; r_qr <= n_qr;
        r_qi <= n_qi; r_tr <= n_tr; r_ti <= n_ti; r_t1 <= n_t1;
        r_acc <= n_acc; r_den <= n_den; r_eps2 <= n_eps2;
        r_sacc <= n_sacc; r_pr <= n_pr; r_pi <= n_pi;
        r_ovf <= n_ovf; r_steps <= n_steps;
        r_prod <= mul_p;
        r_pneg <= mul_a[W-1] ^ mul_b[W-1];
        if (r_state == rncmp_pkg::S_DONE && !r_out_valid) begin
            r_fr <= r_zr;
            r_fi <= r_zi;
            r_fs <= r_steps;
            r_fo <= r_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.final_real    = r_fr;
    assign o_out.final_imag    = r_fi;
    assign o_out.steps_taken   = r_fs;
    assign o_out.overflow_flag = r_fo;

    `include "relaxed_newton_cubic_iteration_top_assert.svh"

    `RNCMP_ASSERT_NEXT(a_accept_starts, i_in.valid && i_in.ready, r_state == rncmp_pkg::S_INIT)
    `RNCMP_ASSERT_NOW(a_div_done_waited, div_rsp.done, r_state == rncmp_pkg::S_QR || r_state == rncmp_pkg::S_QI)
    `RNCMP_ASSERT_NOW(a_steps_bounded, o_out.valid, o_out.steps_taken <= r_max_iter)
endmodule
